/* rtl/ebdr_pkg.sv */
// Shared types and constants for the event batch dedup receiver.
package ebdr_pkg;

  localparam int MaxNodeId   = 15;
  localparam int BatchMax    = 16;
  localparam int EventBytes  = 4;
  localparam int CounterBits = 32;
  localparam int NodeSlots   = MaxNodeId + 1;
  localparam int NodeIdxW    = $clog2(NodeSlots);
  localparam int QueueDepth  = 2;
  localparam logic [15:0] NoAck = 16'hFFFF;

  typedef enum logic [2:0] {
    REQ_HEADER = 3'd0,
    REQ_EVENT  = 3'd1,
    REQ_PONG   = 3'd2,
    REQ_QUERY  = 3'd3,
    REQ_DOWN   = 3'd4
  } req_e;

  typedef enum logic [3:0] {
    ST_HDR_OK    = 4'd0,
    ST_HDR_EPOCH = 4'd1,
    ST_MALFORMED = 4'd2,
    ST_DELIVERED = 4'd3,
    ST_GAP       = 4'd4,
    ST_DUP       = 4'd5,
    ST_DROPPED   = 4'd6,
    ST_PONG      = 4'd7,
    ST_QUERY     = 4'd8,
    ST_DOWN      = 4'd9,
    ST_BAD_NODE  = 4'd10
  } status_e;

  localparam logic [1:0] SEL_MALFORMED = 2'd0;
  localparam logic [1:0] SEL_DUP       = 2'd1;
  localparam logic [1:0] SEL_GAP       = 2'd2;
  localparam logic [1:0] SEL_RECEIVED  = 2'd3;

  // Classified command from front to back
  typedef struct packed {
    req_e        req;
    logic        bad_node;
    logic        malformed;
    logic [7:0]  node;
    logic [7:0]  cnt;
    logic [7:0]  epoch;
    logic [15:0] pseq;
    logic [15:0] eseq;
    logic [1:0]  sel;
  } cmd_t;

endpackage

/* rtl/event_batch_dedup_receiver_top.sv */
// Top level of the event batch dedup receiver.
// Channel | Ports                         | Direction
// in      | in_valid/in_ready + 8 fields  | request in
// out     | out_valid/out_ready + 6 fields| result out
// In the back end a request passes two steps: table read, then update and
// result register. The front queue holds two classified requests.
// Sync reset clears all node tables at once. Unknown request types give no result.
// A stalled output stops the back end; the front keeps filling its queue.
module event_batch_dedup_receiver_top import ebdr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_node_id,
  input  logic [7:0]  in_frame_len,
  input  logic [7:0]  in_event_count,
  input  logic [7:0]  in_batch_epoch,
  input  logic [15:0] in_poll_seq,
  input  logic [15:0] in_event_seq,
  input  logic [1:0]  in_counter_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic [7:0]  out_node_out,
  output logic [15:0] out_event_seq_out,
  output logic        out_deliver,
  output logic [15:0] out_ack_word,
  output logic [31:0] out_counter_value
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  ebdr_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_node_id, .in_frame_len,
    .in_event_count, .in_batch_epoch, .in_poll_seq, .in_event_seq,
    .in_counter_select, .cmd_valid, .cmd_ready, .cmd
  );

  ebdr_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .out_valid, .out_ready,
    .out_status, .out_node_out, .out_event_seq_out, .out_deliver,
    .out_ack_word, .out_counter_value
  );

endmodule

/* rtl/ebdr_front.sv */
// Front end: accepts requests, classifies them and queues commands.
module ebdr_front import ebdr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_node_id,
  input  logic [7:0]  in_frame_len,
  input  logic [7:0]  in_event_count,
  input  logic [7:0]  in_batch_epoch,
  input  logic [15:0] in_poll_seq,
  input  logic [15:0] in_event_seq,
  input  logic [1:0]  in_counter_select,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  cmd_t q_r [QueueDepth];
  logic q_wp_r, q_rp_r;
  logic [1:0] q_cnt_r;
  cmd_t c;
  logic [11:0] need;
  logic push, pop, known;

  // Classification
  always_comb begin
    known = (in_req_type <= REQ_DOWN);
    need = 12'd2 + 12'(in_event_count) * 12'(EventBytes);
    c.req = req_e'(in_req_type);
    c.node = in_node_id;
    c.bad_node = (in_node_id == 8'd0) || (in_node_id > 8'(MaxNodeId));
    c.malformed = (in_frame_len < 8'd2) || (in_event_count > 8'(BatchMax)) ||
                  ({4'd0, in_frame_len} < need);
    c.cnt = in_event_count;
    c.epoch = in_batch_epoch;
    c.pseq = in_poll_seq;
    c.eseq = in_event_seq;
    c.sel = in_counter_select;
  end

  assign in_ready = (q_cnt_r != 2'(QueueDepth));
  assign push = in_valid && in_ready && known;
  assign cmd_valid = (q_cnt_r != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q_r[q_rp_r];

  // Command queue
  always_ff @(posedge clk) begin
    if (push) q_r[q_wp_r] <= c;
    if (!rst_n) begin
      q_wp_r <= 1'b0;
      q_rp_r <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (push) q_wp_r <= ~q_wp_r;
      if (pop) q_rp_r <= ~q_rp_r;
      q_cnt_r <= q_cnt_r + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) q_cnt_r <= 2'(QueueDepth))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !known) |=> $stable(q_cnt_r) || $past(pop))
    else $error("unknown request queued");

endmodule

/* rtl/ebdr_back.sv */
// Back end: node table read-modify-write and result register.
module ebdr_back import ebdr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_status,
  output logic [7:0]  out_node_out,
  output logic [15:0] out_event_seq_out,
  output logic        out_deliver,
  output logic [15:0] out_ack_word,
  output logic [31:0] out_counter_value
);

  logic [7:0]  epoch_r [NodeSlots];
  logic [15:0] next_seq_r [NodeSlots];
  logic [15:0] ack_seq_r [NodeSlots];
  logic [CounterBits-1:0] malf_r [NodeSlots];
  logic [CounterBits-1:0] dup_r [NodeSlots];
  logic [CounterBits-1:0] gap_r [NodeSlots];
  logic [CounterBits-1:0] rcv_r [NodeSlots];
  logic [NodeSlots-1:0] epoch_known_r, seq_known_r, ack_valid_r, alive_r;
  logic [7:0] open_node_r, events_left_r;

  // Stage: 0 = idle, 1 = table read registered
  logic busy_r;
  cmd_t cmd_r;
  logic [NodeIdxW-1:0] idx_r;
  logic [7:0]  rd_epoch_r;
  logic [15:0] rd_next_r, rd_ack_r;
  logic [CounterBits-1:0] rd_cnt_r;
  logic rd_ek_r, rd_sk_r, rd_av_r, rd_al_r;

  logic [NodeIdxW-1:0] idx_c;
  logic take, ev_ok;
  logic [15:0] diff;
  logic [CounterBits-1:0] inc;
  logic [3:0] st;
  logic [7:0] nout;
  logic [15:0] sout, ack;
  logic dlv;
  logic [CounterBits-1:0] cval;

  assign cmd_ready = !busy_r && !(out_valid && !out_ready);
  assign take = cmd_valid && cmd_ready;
  assign idx_c = (cmd.req == REQ_EVENT) ? open_node_r[NodeIdxW-1:0] : cmd.node[NodeIdxW-1:0];

  // Read stage: fetch the node entry and the counter that this command touches
  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd;
      idx_r <= idx_c;
      rd_epoch_r <= epoch_r[idx_c];
      rd_next_r <= next_seq_r[idx_c];
      rd_ack_r <= ack_seq_r[idx_c];
      rd_ek_r <= epoch_known_r[idx_c];
      rd_sk_r <= seq_known_r[idx_c];
      rd_av_r <= ack_valid_r[idx_c];
      rd_al_r <= alive_r[idx_c];
      unique case (cmd.req)
        REQ_HEADER: rd_cnt_r <= malf_r[idx_c];
        REQ_QUERY: begin
          case (cmd.sel)
            SEL_MALFORMED: rd_cnt_r <= malf_r[idx_c];
            SEL_DUP:       rd_cnt_r <= dup_r[idx_c];
            SEL_GAP:       rd_cnt_r <= gap_r[idx_c];
            default:       rd_cnt_r <= rcv_r[idx_c];
          endcase
        end
        REQ_EVENT: rd_cnt_r <= dup_r[idx_c];
        default: rd_cnt_r <= rcv_r[idx_c];
      endcase
    end
  end

  // Execute stage decisions
  always_comb begin
    ev_ok = (events_left_r != 8'd0) && (open_node_r >= 8'd1) &&
            (open_node_r <= 8'(MaxNodeId));
    diff = cmd_r.eseq - rd_next_r;
    inc = rd_cnt_r + 1'b1;
    st = ST_DROPPED;
    nout = cmd_r.node;
    sout = 16'd0;
    ack = NoAck;
    dlv = 1'b0;
    cval = '0;
    unique case (cmd_r.req)
      REQ_EVENT: begin
        nout = open_node_r;
        if (!ev_ok) st = ST_DROPPED;
        else begin
          sout = cmd_r.eseq;
          if (rd_sk_r && diff[15]) st = ST_DUP;
          else begin
            dlv = 1'b1;
            st = (rd_sk_r && diff != 16'd0) ? ST_GAP : ST_DELIVERED;
          end
        end
      end
      REQ_HEADER: begin
        if (cmd_r.bad_node) st = ST_BAD_NODE;
        else if (cmd_r.malformed) st = ST_MALFORMED;
        else begin
          st = (!rd_ek_r || rd_epoch_r != cmd_r.epoch) ? ST_HDR_EPOCH : ST_HDR_OK;
          ack = cmd_r.pseq;
        end
      end
      REQ_PONG: st = cmd_r.bad_node ? ST_BAD_NODE : ST_PONG;
      REQ_QUERY: begin
        if (cmd_r.bad_node) st = ST_BAD_NODE;
        else begin
          st = ST_QUERY;
          ack = rd_av_r ? rd_ack_r : NoAck;
          cval = rd_cnt_r;
        end
      end
      default: st = cmd_r.bad_node ? ST_BAD_NODE : ST_DOWN;
    endcase
  end

  // Write stage and result register
  always_ff @(posedge clk) begin
    if (rst_n && busy_r) begin
      out_status <= st;
      out_node_out <= nout;
      out_event_seq_out <= sout;
      out_deliver <= dlv;
      out_ack_word <= ack;
      out_counter_value <= 32'(cval);
      if (cmd_r.req == REQ_EVENT && ev_ok) begin
        if (st == ST_DUP) dup_r[idx_r] <= dup_r[idx_r] + 1'b1;
        else begin
          next_seq_r[idx_r] <= cmd_r.eseq + 16'd1;
          rcv_r[idx_r] <= rcv_r[idx_r] + 1'b1;
          if (st == ST_GAP) gap_r[idx_r] <= gap_r[idx_r] + 1'b1;
        end
      end
      if (cmd_r.req == REQ_HEADER && !cmd_r.bad_node) begin
        if (cmd_r.malformed) malf_r[idx_r] <= inc;
        else begin
          if (st == ST_HDR_EPOCH) epoch_r[idx_r] <= cmd_r.epoch;
          ack_seq_r[idx_r] <= cmd_r.pseq;
        end
      end
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      out_valid <= 1'b0;
      open_node_r <= 8'd0;
      events_left_r <= 8'd0;
      epoch_known_r <= '0;
      seq_known_r <= '0;
      ack_valid_r <= '0;
      alive_r <= '0;
      for (int i = 0; i < NodeSlots; i++) begin
        epoch_r[i] <= '0;
        next_seq_r[i] <= '0;
        ack_seq_r[i] <= '0;
        malf_r[i] <= '0;
        dup_r[i] <= '0;
        gap_r[i] <= '0;
        rcv_r[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (take) busy_r <= 1'b1;
      if (busy_r) begin
        busy_r <= 1'b0;
        out_valid <= 1'b1;
        unique case (cmd_r.req)
          REQ_EVENT: begin
            if (ev_ok) begin
              events_left_r <= events_left_r - 8'd1;
              if (events_left_r == 8'd1) open_node_r <= 8'd0;
              if (st != ST_DUP) seq_known_r[idx_r] <= 1'b1;
            end
          end
          REQ_HEADER: begin
            if (!cmd_r.bad_node) begin
              if (cmd_r.malformed) begin
                events_left_r <= 8'd0;
                open_node_r <= 8'd0;
              end else begin
                if (st == ST_HDR_EPOCH) begin
                  epoch_known_r[idx_r] <= 1'b1;
                  seq_known_r[idx_r] <= 1'b0;
                end
                ack_valid_r[idx_r] <= 1'b1;
                events_left_r <= cmd_r.cnt;
                open_node_r <= (cmd_r.cnt == 8'd0) ? 8'd0 : cmd_r.node;
              end
            end
          end
          REQ_PONG: begin
            if (!cmd_r.bad_node && !rd_al_r) begin
              alive_r[idx_r] <= 1'b1;
              seq_known_r[idx_r] <= 1'b0;
              ack_valid_r[idx_r] <= 1'b0;
            end
          end
          REQ_DOWN: if (!cmd_r.bad_node) alive_r[idx_r] <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) busy_r |=> !busy_r)
    else $error("execute stage held two cycles");
  assert property (@(posedge clk) disable iff (!rst_n) busy_r |=> out_valid)
    else $error("result not registered");
  assert property (@(posedge clk) disable iff (!rst_n)
    (events_left_r == 8'd0) |-> (open_node_r == 8'd0)) else $error("open node without batch");

endmodule
